### rtl/rfp_pkg.sv
package rfp_pkg;

    // Fixed sizes of the message fields.
    localparam int MIN_PAYLOAD_BYTES = 16;
    localparam int BITRATE_WIDTH     = 64;
    localparam int RATE_PORT_W       = 64;
    localparam int MANT_W            = 18;
    localparam int EXP_W             = 6;
    // Mantissa shifted by the largest exponent.
    localparam int SHIFT_W           = MANT_W + (2 ** EXP_W) - 1;
    localparam int LEN_W             = 17;

    localparam logic [31:0] REMB_TAG = 32'h5245_4D42;

    // Byte positions within the payload.
    localparam logic [15:0] IDX_SENDER_END = 16'd3;
    localparam logic [15:0] IDX_MEDIA_END  = 16'd7;
    localparam logic [15:0] IDX_TAG_END    = 16'd11;
    localparam logic [15:0] IDX_COUNT      = 16'd12;
    localparam logic [15:0] IDX_EXP        = 16'd13;
    localparam logic [15:0] IDX_MANT_MID   = 16'd14;
    localparam logic [15:0] IDX_MANT_LOW   = 16'd15;
    localparam logic [15:0] IDX_LIST_START = 16'd16;
    localparam logic [15:0] IDX_MAX        = 16'hFFFF;

    // Result item kinds.
    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Report status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_IDENT = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // Output queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                   item_kind;
        logic [31:0]            listed_ssrc;
        logic [31:0]            sender_ssrc;
        logic [31:0]            media_source_ssrc;
        logic [RATE_PORT_W-1:0] bitrate_bps;
        logic [7:0]             ssrc_count;
        logic [2:0]             parse_status;
        logic                   end_of_run;
    } out_item_t;

    typedef struct packed {
        logic [RATE_PORT_W-1:0] rate;
        logic                   overflow;
    } rate_t;

    typedef struct packed {
        logic has_room;
    } queue_status_t;

endpackage

### rtl/rfp_rate_decode.sv
module rfp_rate_decode (
    input  logic [rfp_pkg::MANT_W-1:0] mantissa,
    input  logic [rfp_pkg::EXP_W-1:0]  exponent,
    output rfp_pkg::rate_t             result
);

    logic [rfp_pkg::SHIFT_W-1:0] full;

    // The full shifted value is kept so that lost high bits show as overflow.
    always_comb begin
        full = rfp_pkg::SHIFT_W'(mantissa) << exponent;
        result.rate = rfp_pkg::RATE_PORT_W'(full[rfp_pkg::BITRATE_WIDTH-1:0]);
        result.overflow = |full[rfp_pkg::SHIFT_W-1:rfp_pkg::BITRATE_WIDTH];
    end

endmodule

### rtl/rfp_out_queue.sv
module rfp_out_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [1:0]               push_cnt,
    input  rfp_pkg::out_item_t       push_first,
    input  rfp_pkg::out_item_t       push_second,
    output rfp_pkg::queue_status_t   status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rfp_pkg::out_item_t       m_item
);

    rfp_pkg::out_item_t             q_reg  [rfp_pkg::QUEUE_DEPTH];
    rfp_pkg::out_item_t             q_next [rfp_pkg::QUEUE_DEPTH];
    logic [rfp_pkg::QCOUNT_W-1:0]   count_reg;
    logic [rfp_pkg::QCOUNT_W-1:0]   count_next;
    logic [rfp_pkg::QCOUNT_W-1:0]   base;
    logic                           pop;

    assign m_valid          = (count_reg != '0);
    assign m_item           = q_reg[0];
    assign pop              = m_valid && m_ready;
    assign status.has_room  = (count_reg <= rfp_pkg::QCOUNT_W'(rfp_pkg::QUEUE_DEPTH - 2));

    // A shifting queue: the head always sits in slot zero.
    always_comb begin
        base = count_reg - rfp_pkg::QCOUNT_W'(pop);
        for (int i = 0; i < rfp_pkg::QUEUE_DEPTH - 1; i++) begin
            q_next[i] = pop ? q_reg[i+1] : q_reg[i];
        end
        q_next[rfp_pkg::QUEUE_DEPTH-1] = q_reg[rfp_pkg::QUEUE_DEPTH-1];
        for (int i = 0; i < rfp_pkg::QUEUE_DEPTH; i++) begin
            if ((push_cnt != 2'd0) && (rfp_pkg::QCOUNT_W'(i) == base)) begin
                q_next[i] = push_first;
            end
            if ((push_cnt == 2'd2) &&
                (rfp_pkg::QCOUNT_W'(i) == base + rfp_pkg::QCOUNT_W'(1))) begin
                q_next[i] = push_second;
            end
        end
        count_next = base + rfp_pkg::QCOUNT_W'(push_cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < rfp_pkg::QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rfp_pkg::QCOUNT_W'(rfp_pkg::QUEUE_DEPTH))
        else $error("output queue count beyond depth");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (push_cnt == 2'd0)) |=>
            (count_reg == $past(count_reg) - rfp_pkg::QCOUNT_W'(1)))
        else $error("output queue count wrong after pop");

    a_push_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pop && (push_cnt == 2'd2)) |=>
            (count_reg == $past(count_reg) + rfp_pkg::QCOUNT_W'(2)))
        else $error("output queue count wrong after double push");

endmodule

### rtl/remb_feedback_parser_unit.sv
// A byte's results are written into the output queue at the edge that accepts
// it and are offered on the result channel once the items ahead have left.
// Throughput: one byte per cycle; s_ready falls only while the output queue
// holds more than two items, as one byte may cause two results.
// Reset: aresetn is synchronous and active low; it clears the parse state and
// empties the output queue.
module remb_feedback_parser_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rfp_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rfp_pkg::out_item_t  m_item
);

    // Parse state for the packet in progress.
    logic [15:0]                byte_index_reg,    byte_index_next;
    logic [31:0]                word_shift_reg,    word_shift_next;
    logic [31:0]                sender_reg,        sender_next;
    logic [31:0]                media_reg,         media_next;
    logic                       ident_ok_reg,      ident_ok_next;
    logic [7:0]                 count_reg,         count_next;
    logic [rfp_pkg::EXP_W-1:0]  exponent_reg,      exponent_next;
    logic [rfp_pkg::MANT_W-1:0] mantissa_reg,      mantissa_next;
    logic [7:0]                 emitted_count_reg, emitted_count_next;

    logic                       accept;
    logic                       entry_fire;
    logic [rfp_pkg::LEN_W-1:0]  len;
    logic [rfp_pkg::LEN_W-1:0]  need_len;
    logic [1:0]                 push_cnt;
    rfp_pkg::rate_t             rate;
    rfp_pkg::out_item_t         entry_item;
    rfp_pkg::out_item_t         report_item;
    rfp_pkg::out_item_t         push_first;
    rfp_pkg::queue_status_t     q_status;

    assign s_ready = q_status.has_room;
    assign accept  = s_valid && s_ready;

    // Field capture. The report on a last byte sees the fields as updated by
    // that byte, so the decode works from the next-state values.
    always_comb begin
        word_shift_next    = {word_shift_reg[23:0], s_item.data_byte};
        sender_next        = sender_reg;
        media_next         = media_reg;
        ident_ok_next      = ident_ok_reg;
        count_next         = count_reg;
        exponent_next      = exponent_reg;
        mantissa_next      = mantissa_reg;
        emitted_count_next = emitted_count_reg;
        entry_fire         = 1'b0;

        case (byte_index_reg)
            rfp_pkg::IDX_SENDER_END: begin
                sender_next = word_shift_next;
            end
            rfp_pkg::IDX_MEDIA_END: begin
                media_next = word_shift_next;
            end
            rfp_pkg::IDX_TAG_END: begin
                ident_ok_next = (word_shift_next == rfp_pkg::REMB_TAG);
            end
            rfp_pkg::IDX_COUNT: begin
                count_next = s_item.data_byte;
            end
            rfp_pkg::IDX_EXP: begin
                // The low two bits of this byte open the mantissa.
                exponent_next = s_item.data_byte[7:2];
                mantissa_next = rfp_pkg::MANT_W'(s_item.data_byte);
            end
            rfp_pkg::IDX_MANT_MID, rfp_pkg::IDX_MANT_LOW: begin
                mantissa_next = {mantissa_reg[rfp_pkg::MANT_W-9:0], s_item.data_byte};
            end
            default: begin
                // Each fourth byte of the list completes an SSRC; bytes beyond
                // the announced count are ignored.
                if ((byte_index_reg >= rfp_pkg::IDX_LIST_START) &&
                    (byte_index_reg[1:0] == 2'b11) &&
                    (emitted_count_reg < count_reg)) begin
                    entry_fire         = 1'b1;
                    emitted_count_next = emitted_count_reg + 8'd1;
                end
            end
        endcase

        // The byte index saturates on very long payloads.
        byte_index_next = byte_index_reg;
        if (s_item.last_byte) begin
            byte_index_next = '0;
        end else if (byte_index_reg != rfp_pkg::IDX_MAX) begin
            byte_index_next = byte_index_reg + 16'd1;
        end
    end

    rfp_rate_decode u_rate (
        .mantissa (mantissa_next),
        .exponent (exponent_next),
        .result   (rate)
    );

    // Result items. Fields that do not belong to an item kind are zero.
    always_comb begin
        len      = rfp_pkg::LEN_W'(byte_index_reg) + rfp_pkg::LEN_W'(1);
        need_len = rfp_pkg::LEN_W'(rfp_pkg::MIN_PAYLOAD_BYTES) +
                   rfp_pkg::LEN_W'({count_next, 2'b00});

        entry_item                   = '0;
        entry_item.item_kind         = rfp_pkg::KIND_ENTRY;
        entry_item.listed_ssrc       = word_shift_next;
        entry_item.end_of_run        = !s_item.last_byte;

        report_item                  = '0;
        report_item.item_kind        = rfp_pkg::KIND_REPORT;
        report_item.end_of_run       = 1'b1;
        if (len < rfp_pkg::LEN_W'(rfp_pkg::MIN_PAYLOAD_BYTES)) begin
            report_item.parse_status = rfp_pkg::ST_SHORT;
        end else begin
            report_item.sender_ssrc       = sender_next;
            report_item.media_source_ssrc = media_next;
            if (!ident_ok_next) begin
                report_item.parse_status = rfp_pkg::ST_BAD_IDENT;
            end else if (len < need_len) begin
                report_item.ssrc_count   = count_next;
                report_item.parse_status = rfp_pkg::ST_TRUNC;
            end else begin
                report_item.ssrc_count   = count_next;
                report_item.bitrate_bps  = rate.rate;
                report_item.parse_status = rate.overflow ? rfp_pkg::ST_OVERFLOW
                                                         : rfp_pkg::ST_OK;
            end
        end

        // An entry completed by the last byte goes ahead of the report.
        push_first = entry_fire ? entry_item : report_item;
        push_cnt   = 2'd0;
        if (accept) begin
            push_cnt = 2'(entry_fire) + 2'(s_item.last_byte);
        end
    end

    rfp_out_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_cnt    (push_cnt),
        .push_first  (push_first),
        .push_second (report_item),
        .status      (q_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    // A last byte returns the whole parse state to its reset value, ready for
    // the next packet.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_item.last_byte)) begin
            byte_index_reg    <= '0;
            word_shift_reg    <= '0;
            sender_reg        <= '0;
            media_reg         <= '0;
            ident_ok_reg      <= 1'b0;
            count_reg         <= '0;
            exponent_reg      <= '0;
            mantissa_reg      <= '0;
            emitted_count_reg <= '0;
        end else if (accept) begin
            byte_index_reg    <= byte_index_next;
            word_shift_reg    <= word_shift_next;
            sender_reg        <= sender_next;
            media_reg         <= media_next;
            ident_ok_reg      <= ident_ok_next;
            count_reg         <= count_next;
            exponent_reg      <= exponent_next;
            mantissa_reg      <= mantissa_next;
            emitted_count_reg <= emitted_count_next;
        end
    end

    // No more entries leave than the message announces.
    a_emitted_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emitted_count_reg <= count_reg)
        else $error("more SSRC entries emitted than announced");

    // A last byte starts the next packet afresh.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.last_byte) |=> (byte_index_reg == '0 && emitted_count_reg == '0))
        else $error("parse state not cleared after last byte");

    // Entries only appear once the header has been read.
    a_entry_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_fire |-> (byte_index_reg >= rfp_pkg::IDX_LIST_START))
        else $error("SSRC entry emitted inside the header");

endmodule

### sim/remb_result_checker.sv
module remb_result_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  rfp_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  rfp_pkg::out_item_t m_item,
    output int                 mismatch_count,
    output int                 pending_results,
    output int                 entries_checked,
    output int                 reports_checked,
    output int                 reports_flagged
);

    // Shadow copy of the parse state.
    logic [15:0] byte_pos;
    logic [31:0] shift_word;
    logic [31:0] sender_word;
    logic [31:0] media_word;
    logic        ident_match;
    logic [7:0]  announced;
    logic [7:0]  entries_out;
    logic [5:0]  rate_exp;
    logic [17:0] rate_mant;

    rfp_pkg::out_item_t awaited_results[$];
    int                 errors;
    int                 n_entries;
    int                 n_reports;
    int                 n_flagged;

    task automatic clear_parser();
        byte_pos    = '0;
        shift_word  = '0;
        sender_word = '0;
        media_word  = '0;
        ident_match = 1'b0;
        announced   = '0;
        entries_out = '0;
        rate_exp    = '0;
        rate_mant   = '0;
    endtask

    // Appends one predicted item at the tail of the list of awaited items.
    task automatic add_awaited(input rfp_pkg::out_item_t r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    // Works out the items that one payload byte releases and queues them.
    task automatic advance_parser(input rfp_pkg::in_item_t it);
        logic [16:0]        pkt_len;
        logic [16:0]        list_end;
        logic [80:0]        scaled;
        rfp_pkg::out_item_t r;
        shift_word = {shift_word[23:0], it.data_byte};
        case (byte_pos)
            rfp_pkg::IDX_SENDER_END: begin
                sender_word = shift_word;
            end
            rfp_pkg::IDX_MEDIA_END: begin
                media_word = shift_word;
            end
            rfp_pkg::IDX_TAG_END: begin
                ident_match = (shift_word == rfp_pkg::REMB_TAG);
            end
            rfp_pkg::IDX_COUNT: begin
                announced = it.data_byte;
            end
            rfp_pkg::IDX_EXP: begin
                rate_exp  = it.data_byte[7:2];
                rate_mant = {10'd0, it.data_byte};
            end
            rfp_pkg::IDX_MANT_MID, rfp_pkg::IDX_MANT_LOW: begin
                rate_mant = {rate_mant[9:0], it.data_byte};
            end
            default: begin
                if (byte_pos >= rfp_pkg::IDX_LIST_START && byte_pos[1:0] == 2'd3 &&
                    entries_out < announced) begin
                    r = '0;
                    r.item_kind   = rfp_pkg::KIND_ENTRY;
                    r.listed_ssrc = shift_word;
                    r.end_of_run  = !it.last_byte;
                    add_awaited(r);
                    entries_out++;
                end
            end
        endcase

        if (it.last_byte) begin
            pkt_len  = {1'b0, byte_pos} + 17'd1;
            list_end = 17'(rfp_pkg::MIN_PAYLOAD_BYTES) + {7'd0, announced, 2'b00};
            scaled   = {63'd0, rate_mant} << rate_exp;
            r = '0;
            r.item_kind  = rfp_pkg::KIND_REPORT;
            r.end_of_run = 1'b1;
            if (pkt_len < 17'(rfp_pkg::MIN_PAYLOAD_BYTES)) begin
                r.parse_status = rfp_pkg::ST_SHORT;
            end else begin
                r.sender_ssrc       = sender_word;
                r.media_source_ssrc = media_word;
                if (!ident_match) begin
                    r.parse_status = rfp_pkg::ST_BAD_IDENT;
                end else begin
                    r.ssrc_count = announced;
                    if (pkt_len < list_end) begin
                        r.parse_status = rfp_pkg::ST_TRUNC;
                    end else begin
                        r.bitrate_bps  = scaled[63:0];
                        r.parse_status = (|(scaled >> rfp_pkg::BITRATE_WIDTH))
                                       ? rfp_pkg::ST_OVERFLOW : rfp_pkg::ST_OK;
                    end
                end
            end
            add_awaited(r);
            clear_parser();
        end else if (byte_pos != rfp_pkg::IDX_MAX) begin
            byte_pos++;
        end
    endtask

    function automatic string describe(input rfp_pkg::out_item_t r);
        return $sformatf("kind %0d ssrc %h snd %h med %h rate %h cnt %0d st %0d eor %0d",
                         r.item_kind, r.listed_ssrc, r.sender_ssrc, r.media_source_ssrc,
                         r.bitrate_bps, r.ssrc_count, r.parse_status, r.end_of_run);
    endfunction

    task automatic check_result(input rfp_pkg::out_item_t got);
        rfp_pkg::out_item_t want;
        logic               bad;
        if (awaited_results.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected item: %s", describe(got));
            end
            return;
        end
        want = awaited_results.pop_front();
        bad = (got.item_kind !== want.item_kind)
           || (got.listed_ssrc !== want.listed_ssrc)
           || (got.sender_ssrc !== want.sender_ssrc)
           || (got.media_source_ssrc !== want.media_source_ssrc)
           || (got.bitrate_bps !== want.bitrate_bps)
           || (got.ssrc_count !== want.ssrc_count)
           || (got.parse_status !== want.parse_status)
           || (got.end_of_run !== want.end_of_run);
        if (bad) begin
            errors++;
            if (errors <= 10) begin
                $display("item mismatch, expected %s", describe(want));
                $display("                actual %s", describe(got));
            end
        end
        if (want.item_kind == rfp_pkg::KIND_ENTRY) begin
            n_entries++;
        end else begin
            n_reports++;
            if (want.parse_status != rfp_pkg::ST_OK) begin
                n_flagged++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            awaited_results.delete();
        end else begin
            // Outputs at this edge stem from earlier bytes, so check before predicting.
            if (m_valid !== 1'b0 && m_ready) begin
                check_result(m_item);
            end
            if (s_valid && s_ready) begin
                advance_parser(s_item);
            end
        end
        mismatch_count  <= errors;
        pending_results <= awaited_results.size();
        entries_checked <= n_entries;
        reports_checked <= n_reports;
        reports_flagged <= n_flagged;
    end

endmodule

### sim/tb_remb_feedback_parser_unit.sv
module tb_remb_feedback_parser_unit;

    // Far above the slowest plausible run, even with both sides idling.
    localparam int CYCLE_LIMIT = 200_000;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rfp_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rfp_pkg::out_item_t m_item;

    int mismatch_count;
    int pending_results;
    int entries_checked;
    int reports_checked;
    int reports_flagged;

    int cycle_count = 0;
    int bytes_sent  = 0;

    // Random idling of the sender and of the result sink; both are switched
    // off together for one stretch of the run.
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    remb_feedback_parser_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // The checker watches both channels, predicts every item and compares.
    remb_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .entries_checked (entries_checked),
        .reports_checked (reports_checked),
        .reports_flagged (reports_flagged)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // The sink stalls on a random draw with odds of about 23 in a hundred while idling is enabled.
    always @(posedge aclk) begin
        m_ready <= sink_idle_on ? ($urandom_range(0, 99) >= 23) : 1'b1;
    end

    // Offers one byte and returns at the edge where it is accepted. Any idle
    // cycles come first, so valid is never withdrawn once it has been raised.
    task automatic push_byte(input logic [7:0] b, input logic last);
        while (src_idle_on && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{data_byte: b, last_byte: last};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    // Sends a payload of len bytes. The first sixteen carry the fixed header
    // (sender, media source, identifier, count, exponent and mantissa); any
    // bytes beyond that are random, which gives random listed SSRCs and
    // random trailing bytes. A len under sixteen cuts the header short.
    task automatic send_payload(input logic [31:0] snd, input logic [31:0] med,
                                input logic [31:0] tag, input logic [7:0] cnt,
                                input logic [5:0] expo, input logic [17:0] mant,
                                input int len);
        logic [127:0] header;
        logic [7:0]   b;
        header = {snd, med, tag, cnt, expo, mant};
        for (int i = 0; i < len; i++) begin
            if (i < 16) begin
                b = header[127 - 8 * i -: 8];
            end else begin
                b = 8'($urandom);
            end
            push_byte(b, i == len - 1);
        end
    endtask

    // Lowers valid and holds off until every predicted item has come out.
    // The first edge lets the checker's count catch up with the final byte.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
    endtask

    // Mostly well-formed messages with random content, the rest split among
    // truncated lists, corrupted identifiers and payloads that are too short.
    task automatic send_random_payload();
        logic [31:0] tag;
        logic [7:0]  cnt;
        logic [5:0]  expo;
        logic [17:0] mant;
        int          pick;
        int          full_len;
        int          len;
        pick = $urandom_range(0, 99);
        tag  = rfp_pkg::REMB_TAG;
        cnt  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 24))
                                           : 8'($urandom_range(0, 6));
        expo = 6'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                mant = 18'($urandom);
            end
            1: begin
                mant = 18'($urandom_range(0, 255));
            end
            2: begin
                mant = 18'h3FFFF;
            end
            default: begin
                mant = 18'($urandom) >> $urandom_range(0, 17);
            end
        endcase
        full_len = 16 + 4 * cnt;
        len = full_len;
        if (pick < 70) begin
            if ($urandom_range(0, 4) == 0) begin
                len = full_len + $urandom_range(1, 9);
            end
        end else if (pick < 80) begin
            // Half the time the count spans 1 to 255, and the length stays below the
            // full list, so the list is always cut short.
            cnt = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 255))
                                              : 8'($urandom_range(1, 6));
            full_len = 16 + 4 * cnt;
            len = $urandom_range(16, (full_len - 1 < 40) ? full_len - 1 : 40);
        end else if (pick < 90) begin
            tag = ($urandom_range(0, 1) == 0) ? 32'($urandom)
                  : rfp_pkg::REMB_TAG ^ (32'd1 << $urandom_range(0, 31));
            len = full_len + $urandom_range(0, 5);
        end else begin
            len = $urandom_range(1, 15);
        end
        send_payload($urandom, $urandom, tag, cnt, expo, mant, len);
    endtask

    task automatic run_random(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            send_random_payload();
        end
    endtask

    // Guard against a hang: a lost item or a stuck handshake ends up here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_remb_feedback_parser_unit: done, errors");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed payloads. A minimal message with a zero bitrate and no list.
        send_payload(32'hFFFF_FFFF, 32'h0000_0000, rfp_pkg::REMB_TAG, 8'd0, 6'd0, 18'd0, 16);
        // A mantissa of one at the top exponent just fits in 64 bits, and the
        // final byte completes the only entry, so the entry precedes the report.
        send_payload(32'h0000_0000, 32'hFFFF_FFFF, rfp_pkg::REMB_TAG, 8'd1, 6'd63, 18'd1, 20);
        // Full mantissa at the top exponent overflows.
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd1, 6'd63, 18'h3FFFF, 20);
        // Full mantissa: exponent 46 is the largest that fits, 47 overflows.
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd0, 6'd46, 18'h3FFFF, 16);
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd0, 6'd47, 18'h3FFFF, 16);
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd0, 6'd63, 18'd2, 16);
        // Payloads too short to hold the header, down to a single byte.
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd0, 6'd0, 18'd1, 1);
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd0, 6'd0, 18'd1, 4);
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd0, 6'd0, 18'd1, 15);
        // A wrong identifier; its entries still come out ahead of the report.
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG ^ 32'd1, 8'd2, 6'd5, 18'd77, 24);
        // A list announced as three entries but cut off inside the third.
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd3, 6'd9, 18'd1000, 26);
        // Trailing bytes after the list are ignored.
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd1, 6'd12, 18'h2AAAA, 29);
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd0, 6'd3, 18'h15555, 24);
        // The longest announced list cut short, then a long complete list.
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd255, 6'd20, 18'h3FFFF, 16);
        send_payload($urandom, $urandom, rfp_pkg::REMB_TAG, 8'd24, 6'($urandom),
                     18'($urandom), 16 + 4 * 24);

        // Hold the sender back until the block has emptied.
        wait_drained();

        // Random traffic: idling on both sides, then a stretch with none at
        // all, then idling again, with a full drain between the phases.
        run_random(250);
        wait_drained();
        src_idle_on  <= 1'b0;
        sink_idle_on <= 1'b0;
        run_random(150);
        wait_drained();
        src_idle_on  <= 1'b1;
        sink_idle_on <= 1'b1;
        run_random(350);

        wait_drained();
        // Wait on so that a stray late item would still be caught.
        repeat (16) @(posedge aclk);

        $display("run covered %0d payload bytes, with short, truncated, bad and overflowing",
                 bytes_sent);
        $display("messages; %0d SSRC entries and %0d reports (%0d flagged)",
                 entries_checked, reports_checked, reports_flagged);
        if (mismatch_count == 0) begin
            $display("tb_remb_feedback_parser_unit: done, clean");
        end else begin
            $display("tb_remb_feedback_parser_unit: done, errors");
        end
        $finish;
    end

endmodule
